// ===== hdl/swt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swt_pkg;

  // Result kinds, carried on tuser
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  // Line error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LONG     = 3'd1;
  localparam logic [2:0] ERR_MANY     = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED = 3'd3;
  localparam logic [2:0] ERR_CAP      = 3'd4;

  // Quote modes
  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  // Pending escape states
  localparam logic [1:0] ESC_NONE   = 2'd0;
  localparam logic [1:0] ESC_PLAIN  = 2'd1;
  localparam logic [1:0] ESC_DQUOTE = 2'd2;

  // Special bytes
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Field widths
  localparam int unsigned CAP_W  = 9;
  localparam int unsigned TLEN_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd64;

  // One result item
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        ch;
    logic [7:0]        idx;
    logic [TLEN_W-1:0] len;
    logic [2:0]        err;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/shell_word_tokenizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                      Content
// s_axis    in         s_axis_tvalid / s_axis_tready  byte, line end on tlast
// m_axis    out        m_axis_tvalid / m_axis_tready  result, kind on tuser
// cfg       in         cfg_valid_i / cfg_ready_o      token capacity
//
// One item per cycle enters the input register; the step logic turns it into
// zero, one or two results in the same cycle and pushes them into a 4-entry
// result queue. An item passes through the input register and the result queue
// before its first result is valid.
// Reset clears all line state and sets the capacity to 64.
// A stalled output fills the queue; the step waits while fewer than two
// entries are free, and the input register then stops taking items.

module shell_word_tokenizer_core #(
  parameter int unsigned TOKEN_BUFFER_BYTES = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input item
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  wire logic        s_axis_tlast,   // line_end
  // result item
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] char_value, [15:8] token_index,
                                           // [22:16] token_length, [25:23] error_code
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast,   // last
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [swt_pkg::CAP_W-1:0] cfg_data_i  // token_capacity
);

  import swt_pkg::*;

  localparam int unsigned LEN_W = (TOKEN_BUFFER_BYTES > 2) ? $clog2(TOKEN_BUFFER_BYTES) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TOKEN_BUFFER_BYTES - 1);

  // Input register
  logic       inv_q;
  logic [7:0] char_q;
  logic       end_q;

  // Line state and capacity
  logic [1:0]       qm_q, qm_d;
  logic [1:0]       pe_q, pe_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       tok_q, tok_d;
  logic [2:0]       err_q, err_d;
  logic [CAP_W-1:0] cap_q;

  // Result queue
  res_t       fifo_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  logic       proc_fire;
  logic       pop;
  logic [1:0] nres;
  res_t       res_v [2];
  logic [7:0] max_tok;

  assign cfg_ready_o   = 1'b1;
  assign proc_fire     = inv_q && (cnt_q <= 3'd2);
  assign s_axis_tready = !inv_q || proc_fire;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign max_tok       = (cap_q > 9'd256) ? 8'd255 : 8'(cap_q - 9'd1);

  // Take a new item whenever the register empties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (s_axis_tready) begin
      inv_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      char_q <= s_axis_tdata;
      end_q  <= s_axis_tlast;
    end
  end

  // Step logic: one item in, up to two results out
  always_comb begin
    logic [1:0] app_n;
    logic [7:0] app_c [2];
    logic       fin;
    qm_d     = qm_q;
    pe_d     = pe_q;
    len_d    = len_q;
    tok_d    = tok_q;
    err_d    = err_q;
    nres     = 2'd0;
    res_v[0] = '0;
    res_v[1] = '0;
    app_n    = 2'd0;
    app_c[0] = char_q;
    app_c[1] = char_q;
    fin      = 1'b0;

    if (err_d == ERR_NONE && cap_q < 9'd2) begin
      err_d = ERR_CAP;
    end

    // Decode the byte against quote and escape state
    if (!end_q && err_d == ERR_NONE) begin
      case (pe_d)
        ESC_PLAIN: begin
          pe_d  = ESC_NONE;
          app_n = 2'd1;
        end
        ESC_DQUOTE: begin
          pe_d = ESC_NONE;
          if (char_q == CH_DQUOTE || char_q == CH_BSLASH ||
              char_q == CH_DOLLAR || char_q == CH_NL) begin
            app_n = 2'd1;
          end else begin
            // keep the backslash, then the byte itself
            app_n    = 2'd2;
            app_c[0] = CH_BSLASH;
          end
        end
        default: begin
          if (char_q == CH_SQUOTE) begin
            if (qm_d == QM_NONE) qm_d = QM_SINGLE;
            else if (qm_d == QM_SINGLE) qm_d = QM_NONE;
            else app_n = 2'd1;
          end else if (char_q == CH_DQUOTE) begin
            if (qm_d == QM_NONE) qm_d = QM_DOUBLE;
            else if (qm_d == QM_DOUBLE) qm_d = QM_NONE;
            else app_n = 2'd1;
          end else if (char_q == CH_BSLASH && qm_d == QM_DOUBLE) begin
            pe_d = ESC_DQUOTE;
          end else if (char_q == CH_BSLASH && qm_d == QM_NONE) begin
            pe_d = ESC_PLAIN;
          end else if (qm_d == QM_NONE && (char_q == CH_SPACE || char_q == CH_TAB)) begin
            fin = 1'b1;
          end else begin
            app_n = 2'd1;
          end
        end
      endcase
    end

    // Append characters with the length check
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < app_n) begin
        if (len_d >= LEN_MAX) begin
          err_d = ERR_LONG;
        end else begin
          res_v[nres[0]].kind = KIND_CHAR;
          res_v[nres[0]].ch   = app_c[i];
          res_v[nres[0]].idx  = tok_d;
          nres  = nres + 2'd1;
          len_d = len_d + 1'b1;
        end
      end
    end

    // Line end: check quotes before closing the pending token
    if (end_q && err_d == ERR_NONE) begin
      pe_d = ESC_NONE;
      if (qm_d != QM_NONE) err_d = ERR_UNCLOSED;
      else fin = 1'b1;
    end

    // Close the current token, dropping empty ones; too many tokens flags an error
    if (fin && len_d != '0) begin
      if (tok_d >= max_tok) begin
        err_d = ERR_MANY;
      end else begin
        res_v[nres[0]].kind = KIND_END;
        res_v[nres[0]].idx  = tok_d;
        res_v[nres[0]].len  = TLEN_W'(len_d);
        nres  = nres + 2'd1;
        tok_d = tok_d + 8'd1;
        len_d = '0;
      end
    end

    // Report line status and clear line state
    if (end_q) begin
      res_v[nres[0]].kind = (err_d == ERR_NONE) ? KIND_OK : KIND_ERR;
      res_v[nres[0]].idx  = tok_d;
      res_v[nres[0]].err  = err_d;
      nres  = nres + 2'd1;
      qm_d  = QM_NONE;
      pe_d  = ESC_NONE;
      len_d = '0;
      tok_d = 8'd0;
      err_d = ERR_NONE;
    end

    // Mark the final result of this item
    if (nres == 2'd2) res_v[1].last = 1'b1;
    else if (nres == 2'd1) res_v[0].last = 1'b1;
  end

  // Advance line state and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qm_q  <= QM_NONE;
      pe_q  <= ESC_NONE;
      len_q <= '0;
      tok_q <= 8'd0;
      err_q <= ERR_NONE;
      cap_q <= CAP_RESET;
    end else begin
      if (proc_fire) begin
        qm_q  <= qm_d;
        pe_q  <= pe_d;
        len_q <= len_d;
        tok_q <= tok_d;
        err_q <= err_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (proc_fire) wr_q <= wr_q + nres;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + (proc_fire ? {1'b0, nres} : 3'd0) - {2'b00, pop};
    end
  end

  // Write the results of one item
  always_ff @(posedge clk_i) begin
    if (proc_fire && nres != 2'd0) begin
      fifo_q[wr_q] <= res_v[0];
    end
    if (proc_fire && nres == 2'd2) begin
      fifo_q[wr_q + 2'd1] <= res_v[1];
    end
  end

  // Drive the result channel from the queue head
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tdata  = {6'b0, fifo_q[rd_q].err, fifo_q[rd_q].len,
                          fifo_q[rd_q].idx, fifo_q[rd_q].ch};
  assign m_axis_tuser  = fifo_q[rd_q].kind;
  assign m_axis_tlast  = fifo_q[rd_q].last;

  // Assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result queue over its depth");

  a_esc_in_dq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pe_q == ESC_DQUOTE |-> qm_q == QM_DOUBLE)
    else $error("double-quote escape pending outside double quotes");

  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && end_q |=> qm_q == QM_NONE && tok_q == 8'd0 && len_q == '0 &&
                          err_q == ERR_NONE)
    else $error("line state not cleared after line end");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_OK || m_axis_tuser == KIND_ERR) |->
      m_axis_tlast)
    else $error("line status not marked last");

  a_char_noerr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_CHAR |-> m_axis_tdata[25:23] == ERR_NONE)
    else $error("token character carries an error code");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import swt_pkg::*;

  localparam int unsigned WORD_BUF     = 128;
  localparam int unsigned MAX_WORD_LEN = WORD_BUF - 1;
  localparam int unsigned TOTAL_ITEMS  = 1250;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 6;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = 8'h00;   // [7:0] char_in
  logic              s_axis_tlast  = 1'b0;    // line_end
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;            // [7:0] char_value, [15:8] token_index,
                                              // [22:16] token_length, [25:23] error_code
  logic [1:0]        m_axis_tuser;            // [1:0] kind
  logic              m_axis_tlast;            // last
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CAP_W-1:0]  cfg_data_i    = CAP_RESET; // token_capacity

  shell_word_tokenizer_core #(
    .TOKEN_BUFFER_BYTES(WORD_BUF)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Tokenizer mirror state
  logic [CAP_W-1:0] capacity   = CAP_RESET;
  logic [1:0]       quote_st   = QM_NONE;
  logic [1:0]       esc_st     = ESC_NONE;
  int unsigned      word_len   = 0;
  int unsigned      word_count = 0;
  logic [2:0]       line_err   = ERR_NONE;

  res_t        item_events[$];
  res_t        pending_events[$];
  int unsigned n_fail   = 0;
  int unsigned n_sent   = 0;
  int unsigned n_cycles = 0;
  bit          tx_calm  = 1'b0;
  bit          rx_calm  = 1'b0;
  int unsigned rx_hold  = 0;

  function automatic void add_event(input kind_e k, input logic [7:0] ch,
                                    input int unsigned idx, input int unsigned len,
                                    input logic [2:0] err);
    res_t r;
    r.kind = k;
    r.ch   = ch;
    r.idx  = idx[7:0];
    r.len  = len[TLEN_W-1:0];
    r.err  = err;
    r.last = 1'b0;
    item_events.push_back(r);
  endfunction

  function automatic bit push_char(input logic [7:0] c);
    if (word_len >= MAX_WORD_LEN) begin
      line_err = ERR_LONG;
      return 1'b0;
    end
    add_event(KIND_CHAR, c, word_count, 0, ERR_NONE);
    word_len++;
    return 1'b1;
  endfunction

  function automatic void close_word();
    int unsigned cap;
    cap = (capacity > 256) ? 256 : capacity;
    if (word_len == 0) return;
    if (word_count >= cap - 1) begin
      line_err = ERR_MANY;
      return;
    end
    add_event(KIND_END, 8'h00, word_count, word_len, ERR_NONE);
    word_count++;
    word_len = 0;
  endfunction

  // Handle a byte with no escape pending
  function automatic void take_plain(input logic [7:0] c);
    logic [1:0] m;
    if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      m = (c == CH_SQUOTE) ? QM_SINGLE : QM_DOUBLE;
      if (quote_st == QM_NONE) quote_st = m;
      else if (quote_st == m) quote_st = QM_NONE;
      else void'(push_char(c));
      return;
    end
    if (c == CH_BSLASH && quote_st == QM_DOUBLE) begin
      esc_st = ESC_DQUOTE;
      return;
    end
    if (c == CH_BSLASH && quote_st == QM_NONE) begin
      esc_st = ESC_PLAIN;
      return;
    end
    if (quote_st == QM_NONE && (c == CH_SPACE || c == CH_TAB)) begin
      close_word();
      return;
    end
    void'(push_char(c));
  endfunction

  // Work out the results of one accepted item and queue them
  function automatic void tokenize_byte(input logic [7:0] c, input bit eol);
    res_t r;
    item_events.delete();
    if (line_err == ERR_NONE && capacity < 2) line_err = ERR_CAP;
    if (!eol) begin
      if (line_err == ERR_NONE) begin
        if (esc_st == ESC_PLAIN) begin
          esc_st = ESC_NONE;
          void'(push_char(c));
        end else if (esc_st == ESC_DQUOTE) begin
          esc_st = ESC_NONE;
          if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR || c == CH_NL) begin
            void'(push_char(c));
          end else if (push_char(CH_BSLASH)) begin
            take_plain(c);
          end
        end else begin
          take_plain(c);
        end
      end
    end else begin
      if (line_err == ERR_NONE) begin
        esc_st = ESC_NONE;
        if (quote_st != QM_NONE) line_err = ERR_UNCLOSED;
        else close_word();
      end
      if (line_err == ERR_NONE) add_event(KIND_OK, 8'h00, word_count, 0, ERR_NONE);
      else add_event(KIND_ERR, 8'h00, word_count, 0, line_err);
      quote_st   = QM_NONE;
      esc_st     = ESC_NONE;
      word_len   = 0;
      word_count = 0;
      line_err   = ERR_NONE;
    end
    if (item_events.size() != 0) begin
      r = item_events.pop_back();
      r.last = 1'b1;
      item_events.push_back(r);
    end
    foreach (item_events[i]) pending_events.push_back(item_events[i]);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Random byte, skipping the classes that are masked off
  function automatic logic [7:0] pick_byte(input bit no_sep, input bit no_sq,
                                           input bit no_dq, input bit no_bs);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((no_sep && (c == CH_SPACE || c == CH_TAB)) || (no_sq && c == CH_SQUOTE) ||
               (no_dq && c == CH_DQUOTE) || (no_bs && c == CH_BSLASH));
    return c;
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return CAP_W'($urandom_range(0, 1));
    if (r == 1) return CAP_W'($urandom_range(256, 511));
    if (r < 10) return CAP_W'($urandom_range(2, 6));
    return CAP_W'($urandom_range(7, 80));
  endfunction

  // Present one item and hold it until accepted
  task automatic send_byte(input logic [7:0] c, input bit eol);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eol;
    do @(posedge clk_i); while (!s_axis_tready);
    tokenize_byte(c, eol);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_eol();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_plain_run(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(pick_byte(1, 1, 1, 1), 1'b0);
  endtask

  // Line of n single-byte words
  task automatic send_words(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_plain_run(1);
      send_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB, 1'b0);
    end
    send_eol();
  endtask

  // Write the capacity only once the block has gone quiet
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity = v;
    cfg_valid_i <= 1'b0;
  endtask

  // Quoting, escapes, separators, zero and high bytes, unclosed quotes
  task automatic test_basic_quoting();
    send_text("a\\ x\t'\"'\"\\$\\q\"");
    send_eol();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("  \\");
    send_eol();
    send_text("\"\\");
    send_eol();
    send_text("'");
    send_eol();
  endtask

  // Reset capacity allows 63 words; the 64th fails the line
  task automatic test_reset_word_limit();
    send_words(64);
  endtask

  // Capacity 0 and 1 fail at once; capacity 2 allows a single word
  task automatic test_small_capacity();
    write_capacity(9'd0);
    send_eol();
    send_text("ab");
    send_eol();
    write_capacity(9'd1);
    send_text("a b");
    send_eol();
    write_capacity(9'd2);
    send_text("a b c");
    send_eol();
    send_text("solo");
    send_eol();
  endtask

  // A capacity beyond the table size fills the table, then fails
  task automatic test_large_capacity();
    tx_calm = 1'b1;
    write_capacity(9'd511);
    send_words(256);
    tx_calm = 1'b0;
  endtask

  // Word length limit, also when a kept backslash hits it
  task automatic test_long_words();
    write_capacity(pick_capacity() | 9'd4);
    send_plain_run(MAX_WORD_LEN);
    send_eol();
    send_plain_run(MAX_WORD_LEN - 1);
    send_text("\"\\z\"");
    send_eol();
  endtask

  // Mostly well-formed words built from quoted and escaped pieces
  task automatic send_words_line();
    int unsigned n_words;
    int unsigned n_parts;
    n_words = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) send_byte(CH_SPACE, 1'b0);
    for (int unsigned w = 0; w < n_words; w++) begin
      n_parts = $urandom_range(1, 4);
      for (int unsigned p = 0; p < n_parts; p++) begin
        case ($urandom_range(0, 3))
          0: begin
            send_plain_run($urandom_range(1, 5));
          end
          1: begin
            send_byte(CH_SQUOTE, 1'b0);
            repeat ($urandom_range(0, 5)) send_byte(pick_byte(0, 1, 0, 0), 1'b0);
            send_byte(CH_SQUOTE, 1'b0);
          end
          2: begin
            send_byte(CH_DQUOTE, 1'b0);
            repeat ($urandom_range(0, 5)) begin
              case ($urandom_range(0, 5))
                0: begin
                  send_byte(CH_BSLASH, 1'b0);
                  case ($urandom_range(0, 3))
                    0: send_byte(CH_DQUOTE, 1'b0);
                    1: send_byte(CH_BSLASH, 1'b0);
                    2: send_byte(CH_DOLLAR, 1'b0);
                    default: send_byte(CH_NL, 1'b0);
                  endcase
                end
                1: begin
                  send_byte(CH_BSLASH, 1'b0);
                  send_byte(pick_byte(0, 0, 0, 0), 1'b0);
                end
                2: send_byte(CH_SQUOTE, 1'b0);
                default: send_byte(pick_byte(0, 0, 1, 1), 1'b0);
              endcase
            end
            send_byte(CH_DQUOTE, 1'b0);
          end
          default: begin
            send_byte(CH_BSLASH, 1'b0);
            send_byte(pick_byte(0, 0, 0, 0), 1'b0);
          end
        endcase
      end
      repeat ($urandom_range(1, 2)) begin
        send_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB, 1'b0);
      end
    end
    send_eol();
  endtask

  // Random bytes, heavy on the special ones
  task automatic send_noise_line();
    logic [7:0] specials [7];
    specials = '{CH_SQUOTE, CH_DQUOTE, CH_BSLASH, CH_SPACE, CH_TAB, CH_DOLLAR, CH_NL};
    repeat ($urandom_range(0, 24)) begin
      if ($urandom_range(0, 1) != 0) send_byte(specials[$urandom_range(0, 6)], 1'b0);
      else send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    send_eol();
  endtask

  // Fill up the item budget with random lines
  task automatic test_random_lines();
    while (n_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 11) == 0) write_capacity(pick_capacity());
      tx_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 80) send_words_line();
      else send_noise_line();
    end
    tx_calm = 1'b0;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  // Compare each accepted result, then pick the next stall
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result: kind %0d, data %h", m_axis_tuser, m_axis_tdata);
        n_fail++;
      end else begin
        want = pending_events.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("char_value", want.ch, m_axis_tdata[7:0]);
        check_field("token_index", want.idx, m_axis_tdata[15:8]);
        check_field("token_length", want.len, m_axis_tdata[22:16]);
        check_field("error_code", want.err, m_axis_tdata[25:23]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
    if ($urandom_range(0, 299) == 0) rx_calm <= ~rx_calm;
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_quoting();
    test_reset_word_limit();
    test_small_capacity();
    test_large_capacity();
    test_long_words();
    test_random_lines();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/swt_pkg.sv
hdl/shell_word_tokenizer_core.sv
sim/tb_top.sv
